// ----- hdl/dufp_pkg.sv -----
// Package with shared constants, types and command/status structs for the edge pruner.
`timescale 1ns / 1ps
package dufp_pkg;
  localparam int MAX_NODES = 256;
  localparam int MAX_EDGES = 1024;
  localparam int NODE_W = 9;
  localparam int IDX_W = 8;
  localparam int EADDR_W = 10;
  localparam int ECNT_W = 11;
  localparam int RANK_W = 4;
  localparam logic [1:0] TYPE_FIRST = 2'd1;
  localparam logic [1:0] TYPE_SECOND = 2'd2;
  localparam logic [1:0] TYPE_SHARED = 2'd3;

  typedef struct packed {
    logic [1:0] etype;
    logic [NODE_W-1:0] u;
    logic [NODE_W-1:0] v;
  } edge_t;

  // controller -> datapath
  typedef struct packed {
    logic store_wr;     // write input edge at edge_total
    logic clr_edges;    // reset edge_total / dropped
    logic init_start;   // begin forest init
    logic rd_edge;      // read edge at pointer
    logic ptr_clr;
    logic ptr_inc;
    logic ld_edge;      // latch edge from memory read data
    logic find_a_start; // start find of u
    logic find_b_start; // start find of v
    logic find_step;    // walk one link
    logic comp_start;   // start compression of current node
    logic comp_step;
    logic do_union;     // link roots and count
    logic sel_second;   // 0 first forest, 1 second forest
    logic kept_or;      // accumulate join result
    logic kept_commit;  // add to kept_r
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_done;
    logic ptr_end;
    logic edge_skip;    // edge not valid for this pass
    logic edge_shared;
    logic edge_second;
    logic find_done;
    logic comp_done;
  } sts_t;
endpackage

// ----- hdl/dufp_if.sv -----
// Valid/ready channel interfaces for edge input, result output and configuration.
`timescale 1ns / 1ps
interface dufp_in_if;
  logic valid;
  logic ready;
  logic [1:0] edge_type;
  logic [8:0] node_u;
  logic [8:0] node_v;
  logic last;
  modport source(output valid, edge_type, node_u, node_v, last, input ready);
  modport sink(input valid, edge_type, node_u, node_v, last, output ready);
endinterface

interface dufp_out_if;
  logic valid;
  logic ready;
  logic [10:0] removable;
  logic traversable;
  logic overflow;
  modport source(output valid, removable, traversable, overflow, input ready);
  modport sink(input valid, removable, traversable, overflow, output ready);
endinterface

interface dufp_cfg_if;
  logic valid;
  logic ready;
  logic [8:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- hdl/dufp_datapath.sv -----
// Datapath: edge store, two parent/rank forests, find walk, compression, union and counters.
`timescale 1ns / 1ps
module dufp_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dufp_pkg::cmd_t               cmd,
  output dufp_pkg::sts_t               sts,
  input  dufp_pkg::edge_t              in_edge,
  input  logic [dufp_pkg::NODE_W-1:0]  node_count,
  output logic [dufp_pkg::ECNT_W-1:0]  removable,
  output logic                         traversable,
  output logic                         overflow
);
  localparam int NW = dufp_pkg::NODE_W;
  localparam int IW = dufp_pkg::IDX_W;
  localparam int RW = dufp_pkg::RANK_W;

  // Edge store.
  dufp_pkg::edge_t edge_mem [dufp_pkg::MAX_EDGES];
  dufp_pkg::edge_t rd_q;
  logic [dufp_pkg::ECNT_W-1:0] edge_total_r;
  logic dropped_r;
  logic [dufp_pkg::ECNT_W-1:0] ptr_r;

  always_ff @(posedge clk) begin
    if (cmd.store_wr && !edge_total_r[dufp_pkg::ECNT_W-1])
      edge_mem[edge_total_r[dufp_pkg::EADDR_W-1:0]] <= in_edge;
    if (cmd.rd_edge) rd_q <= edge_mem[ptr_r[dufp_pkg::EADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_edges) begin
      edge_total_r <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.store_wr) begin
      if (edge_total_r[dufp_pkg::ECNT_W-1]) dropped_r <= 1'b1;
      else edge_total_r <= edge_total_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.ptr_clr) ptr_r <= '0;
    else if (cmd.ptr_inc) ptr_r <= ptr_r + 1'b1;
  end
  assign sts.ptr_end = (ptr_r == edge_total_r);

  // Clamped node count.
  logic [NW-1:0] n_cl;
  always_comb begin
    n_cl = node_count;
    if (node_count == '0) n_cl = NW'(1);
    else if (node_count > NW'(dufp_pkg::MAX_NODES)) n_cl = NW'(dufp_pkg::MAX_NODES);
  end

  // Latched current edge; nodes stored as index id-1.
  dufp_pkg::edge_t e_r;
  always_ff @(posedge clk) if (cmd.ld_edge) e_r <= rd_q;
  logic e_shared, e_bad;
  logic ptr_pass_r; // 0 shared pass, 1 other pass
  assign e_shared = (e_r.etype == dufp_pkg::TYPE_SHARED);
  assign e_bad = (e_r.u == '0) || (e_r.u > n_cl) || (e_r.v == '0) || (e_r.v > n_cl);
  assign sts.edge_shared = e_shared;
  assign sts.edge_second = (e_r.etype == dufp_pkg::TYPE_SECOND);
  assign sts.edge_skip = e_bad || (e_shared != ~ptr_pass_r);
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init_start) ptr_pass_r <= 1'b0;
    else if (cmd.ptr_clr) ptr_pass_r <= 1'b1;
  end

  // Forest memories: one read and one write a cycle each, read data registered.
  logic [IW-1:0] par1 [dufp_pkg::MAX_NODES];
  logic [IW-1:0] par2 [dufp_pkg::MAX_NODES];
  logic [RW-1:0] rk1 [dufp_pkg::MAX_NODES];
  logic [RW-1:0] rk2 [dufp_pkg::MAX_NODES];

  logic [IW-1:0] init_idx_r;
  logic          init_run_r;
  logic [IW-1:0] cur_r, root_r, ra_r, start_r;
  logic [IW-1:0] p_q;       // parent read data
  logic [RW-1:0] rk_a_r, rk_b_r, rk_q;
  logic [RW-1:0] rk_hold_r;
  logic          rd_pend_r; // read issued last cycle
  logic [NW-1:0] comp1_r, comp2_r;
  logic [dufp_pkg::ECNT_W-1:0] kept_r;
  logic kept_acc_r;
  logic which_r;            // 0 finding u, 1 finding v

  // address of parent read
  logic [IW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [IW-1:0] wr_addr, wr_data;
  logic rk_wr;
  logic [IW-1:0] rk_addr;
  logic [RW-1:0] rk_data;

  logic [IW-1:0] u_i, v_i;
  assign u_i = IW'(e_r.u - 1'b1);
  assign v_i = IW'(e_r.v - 1'b1);

  // Find state: cur_r walks; when p_q == cur_r, root found.
  logic at_root;
  assign at_root = rd_pend_r && (p_q == cur_r);
  assign sts.find_done = at_root;
  assign sts.comp_done = rd_pend_r && (cur_r == root_r);
  assign sts.init_done = init_run_r && (init_idx_r == IW'(dufp_pkg::MAX_NODES - 1));

  always_comb begin
    rd_en = 1'b0;
    rd_addr = cur_r;
    wr_en = 1'b0;
    wr_addr = cur_r;
    wr_data = root_r;
    rk_wr = 1'b0;
    rk_addr = root_r;
    rk_data = '0;
    if (cmd.find_a_start) begin
      rd_en = 1'b1; rd_addr = u_i;
    end else if (cmd.find_b_start) begin
      rd_en = 1'b1; rd_addr = v_i;
    end else if (cmd.find_step && rd_pend_r && !at_root) begin
      rd_en = 1'b1; rd_addr = p_q;
    end else if (cmd.comp_start) begin
      rd_en = 1'b1; rd_addr = start_r;
    end else if (cmd.comp_step && rd_pend_r && cur_r != root_r) begin
      wr_en = 1'b1; wr_addr = cur_r; wr_data = root_r;
      rd_en = 1'b1; rd_addr = p_q;
    end
    if (init_run_r) begin
      wr_en = 1'b1; wr_addr = init_idx_r; wr_data = init_idx_r;
      rk_wr = 1'b1; rk_addr = init_idx_r; rk_data = '0;
    end else if (cmd.do_union) begin
      wr_en = 1'b1;
      if (rk_a_r > rk_b_r) begin
        wr_addr = root_r; wr_data = ra_r;
      end else begin
        wr_addr = ra_r; wr_data = root_r;
        if (rk_a_r == rk_b_r && rk_b_r != '1) begin
          rk_wr = 1'b1; rk_addr = root_r; rk_data = rk_b_r + 1'b1;
        end
      end
    end
  end

  logic do_join;
  assign do_join = cmd.do_union && (ra_r != root_r);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      p_q  <= cmd.sel_second ? par2[rd_addr] : par1[rd_addr];
      rk_q <= cmd.sel_second ? rk2[rd_addr] : rk1[rd_addr];
    end
    if (wr_en && (init_run_r || !cmd.sel_second)) par1[wr_addr] <= wr_data;
    if (wr_en && (init_run_r || cmd.sel_second))  par2[wr_addr] <= wr_data;
    if (rk_wr && (init_run_r || !cmd.sel_second) && (init_run_r || do_join))
      rk1[rk_addr] <= rk_data;
    if (rk_wr && (init_run_r || cmd.sel_second) && (init_run_r || do_join))
      rk2[rk_addr] <= rk_data;
  end
  // Note: the parent write in do_union is harmless when roots match (self link).

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      init_run_r <= 1'b0;
      init_idx_r <= '0;
    end else begin
      rd_pend_r <= rd_en;
      if (cmd.init_start) begin
        init_run_r <= 1'b1; init_idx_r <= '0;
      end else if (init_run_r) begin
        if (init_idx_r == IW'(dufp_pkg::MAX_NODES - 1)) init_run_r <= 1'b0;
        init_idx_r <= init_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find_a_start) begin
      cur_r <= u_i; start_r <= u_i; which_r <= 1'b0;
    end else if (cmd.find_b_start) begin
      cur_r <= v_i; start_r <= v_i; which_r <= 1'b1;
    end else if (cmd.find_step && rd_pend_r) begin
      if (at_root) begin
        root_r <= cur_r;
        if (which_r) rk_b_r <= rk_q;
      end else cur_r <= p_q;
    end else if (cmd.comp_start) begin
      cur_r <= start_r;
    end else if (cmd.comp_step && rd_pend_r && cur_r != root_r) begin
      cur_r <= p_q;
    end
    // after first root's compression, keep it as ra
    if (cmd.find_b_start) begin
      ra_r <= root_r;
      rk_a_r <= rk_hold_r;
    end
  end
  always_ff @(posedge clk) if (cmd.find_step && at_root && !which_r) rk_hold_r <= rk_q;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init_start) begin
      comp1_r <= n_cl; comp2_r <= n_cl; kept_r <= '0; kept_acc_r <= 1'b0;
    end else begin
      if (do_join && !cmd.sel_second && comp1_r != '0) comp1_r <= comp1_r - 1'b1;
      if (do_join && cmd.sel_second && comp2_r != '0) comp2_r <= comp2_r - 1'b1;
      if (cmd.kept_commit) begin
        if (kept_acc_r || do_join) kept_r <= kept_r + 1'b1;
        kept_acc_r <= 1'b0;
      end else if (cmd.kept_or && do_join) kept_acc_r <= 1'b1;
    end
  end

  assign traversable = (comp1_r == NW'(1)) && (comp2_r == NW'(1));
  assign removable = traversable ? (edge_total_r - kept_r) : '0;
  assign overflow = dropped_r;
endmodule

// ----- hdl/dufp_ctrl.sv -----
// Controller state machine sequencing load, forest init, the shared and other edge passes, finds and unions.
`timescale 1ns / 1ps
module dufp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           in_last,
  output logic           in_rdy,
  output logic           out_vld,
  input  logic           out_rdy,
  output dufp_pkg::cmd_t cmd,
  input  dufp_pkg::sts_t sts
);
  typedef enum logic [13:0] {
    S_LOAD   = 14'b00000000000001,
    S_INIT   = 14'b00000000000010,
    S_RD     = 14'b00000000000100,
    S_LD     = 14'b00000000001000,
    S_CHK    = 14'b00000000010000,
    S_FA     = 14'b00000000100000,
    S_CA     = 14'b00000001000000,
    S_FB     = 14'b00000010000000,
    S_CB     = 14'b00000100000000,
    S_UNION  = 14'b00001000000000,
    S_NEXT   = 14'b00010000000000,
    S_PASS   = 14'b00100000000000,
    S_OUT    = 14'b01000000000000,
    S_WAIT   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic pass_r, pass_nxt;     // 0 shared pass, 1 other
  logic fsec_r, fsec_nxt;     // forest in use
  logic fa_r, fa_nxt;         // find start issued

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; pass_r <= 1'b0; fsec_r <= 1'b0; fa_r <= 1'b0;
    end else begin
      state_r <= state_nxt; pass_r <= pass_nxt; fsec_r <= fsec_nxt;
      fa_r <= fa_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt = pass_r;
    fsec_nxt = fsec_r;
    fa_nxt = fa_r;
    cmd = '0;
    cmd.sel_second = fsec_r;
    in_rdy = 1'b0;
    out_vld = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_rdy = 1'b1;
        cmd.store_wr = in_fire;
        if (in_fire && in_last) begin
          cmd.init_start = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        pass_nxt = 1'b0;
        if (sts.init_done) begin
          cmd.ptr_clr = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_edge = 1'b1;
        if (sts.ptr_end) state_nxt = S_PASS;
        else state_nxt = S_LD;
      end
      S_LD: begin
        cmd.ld_edge = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        fsec_nxt = sts.edge_second;
        fa_nxt = 1'b0;
        if (sts.edge_skip) state_nxt = S_NEXT;
        else state_nxt = S_FA;
      end
      S_FA: begin
        if (!fa_r) begin
          cmd.find_a_start = 1'b1; fa_nxt = 1'b1;
        end else begin
          cmd.find_step = 1'b1;
          if (sts.find_done) begin
            fa_nxt = 1'b0; state_nxt = S_CA;
          end
        end
      end
      S_CA: begin
        if (!fa_r) begin
          cmd.comp_start = 1'b1; fa_nxt = 1'b1;
        end else begin
          cmd.comp_step = 1'b1;
          if (sts.comp_done) begin
            fa_nxt = 1'b0; state_nxt = S_FB;
          end
        end
      end
      S_FB: begin
        if (!fa_r) begin
          cmd.find_b_start = 1'b1; fa_nxt = 1'b1;
        end else begin
          cmd.find_step = 1'b1;
          if (sts.find_done) begin
            fa_nxt = 1'b0; state_nxt = S_CB;
          end
        end
      end
      S_CB: begin
        if (!fa_r) begin
          cmd.comp_start = 1'b1; fa_nxt = 1'b1;
        end else begin
          cmd.comp_step = 1'b1;
          if (sts.comp_done) begin
            fa_nxt = 1'b0; state_nxt = S_UNION;
          end
        end
      end
      S_UNION: begin
        cmd.do_union = 1'b1;
        if (sts.edge_shared && !fsec_r) begin
          cmd.kept_or = 1'b1;
          fsec_nxt = 1'b1;
          state_nxt = S_FA;
        end else begin
          cmd.kept_commit = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.ptr_inc = 1'b1;
        fsec_nxt = 1'b0;
        state_nxt = S_RD;
      end
      S_PASS: begin
        if (!pass_r) begin
          pass_nxt = 1'b1;
          cmd.ptr_clr = 1'b1;
          state_nxt = S_RD;
        end else state_nxt = S_OUT;
      end
      S_OUT: begin
        out_vld = 1'b1;
        if (out_rdy) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        cmd.clr_edges = 1'b1;
        cmd.ptr_clr = 1'b1;
        state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end
endmodule

// ----- hdl/dual_union_find_edge_pruner.sv -----
// Top level of the two-user union-find edge pruner.
// Loading: one edge word is taken per cycle in the load state. After the last word the
// forests are initialised, then each stored edge is read and checked in each pass, and
// an edge of that pass goes through its find walks, compressions and union; the result word follows the second pass.
// Throughput: one edge set at a time; the find walks over the parent memory set the pace.
// Reset: synchronous active-low rst_n empties the edge store and sets node_count to 256.
`timescale 1ns / 1ps
module dual_union_find_edge_pruner (
  input logic clk,
  input logic rst_n,
  dufp_in_if.sink    in_ch,
  dufp_out_if.source out_ch,
  dufp_cfg_if.sink   cfg_ch
);
  dufp_pkg::cmd_t cmd;
  dufp_pkg::sts_t sts;
  logic [dufp_pkg::NODE_W-1:0] node_count_r;
  logic in_rdy, out_vld;
  dufp_pkg::edge_t in_edge;

  // Configuration is always accepted; the block reads the register at init and in each edge check.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= 9'd256;
    else if (cfg_ch.valid) node_count_r <= cfg_ch.data;
  end

  assign in_ch.ready = in_rdy;
  assign out_ch.valid = out_vld;
  assign in_edge.etype = in_ch.edge_type;
  assign in_edge.u = in_ch.node_u;
  assign in_edge.v = in_ch.node_v;

  dufp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_ch.valid && in_rdy), .in_last(in_ch.last), .in_rdy(in_rdy),
    .out_vld(out_vld), .out_rdy(out_ch.ready), .cmd(cmd), .sts(sts)
  );

  dufp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_edge(in_edge),
    .node_count(node_count_r), .removable(out_ch.removable),
    .traversable(out_ch.traversable), .overflow(out_ch.overflow)
  );
endmodule

// ----- verif/tb_dual_union_find_edge_pruner.sv -----
// Self-checking testbench for the two-user union-find edge pruner.
`timescale 1ns / 1ps
module tb_dual_union_find_edge_pruner;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [10:0] removable;
    logic        traversable;
    logic        overflow;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dufp_in_if  in_ch();
  dufp_out_if out_ch();
  dufp_cfg_if cfg_ch();

  dual_union_find_edge_pruner u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // Predictor state: the stored edge set, the node count and both forests.
  dufp_pkg::edge_t edge_list[$];
  logic [8:0]     nodes_cfg = 9'd256;
  logic           dropped = 1'b0;
  int             par_a[dufp_pkg::MAX_NODES+1], rank_a[dufp_pkg::MAX_NODES+1];
  int             par_b[dufp_pkg::MAX_NODES+1], rank_b[dufp_pkg::MAX_NODES+1];
  int             comps_a, comps_b;

  verdict_t       verdict_queue[$];
  int             fail_count = 0;
  int             cycle_count = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  bit             recv_hold = 1'b0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[dual_union_find_edge_pruner] ERROR");
      $finish;
    end
  end

  function automatic int find_root(ref int par[dufp_pkg::MAX_NODES+1], input int x);
    int r, nx;
    r = x;
    while (par[r] != r) r = par[r];
    while (par[x] != r) begin
      nx = par[x];
      par[x] = r;
      x = nx;
    end
    return r;
  endfunction

  function automatic bit link_nodes(ref int par[dufp_pkg::MAX_NODES+1],
                                    ref int rk[dufp_pkg::MAX_NODES+1],
                                    ref int comps, input int a, input int b);
    int ra, rb;
    ra = find_root(par, a);
    rb = find_root(par, b);
    if (ra == rb) return 1'b0;
    if (rk[ra] > rk[rb]) begin
      par[rb] = ra;
    end else if (rk[ra] < rk[rb]) begin
      par[ra] = rb;
    end else begin
      par[ra] = rb;
      if (rk[rb] < 15) rk[rb]++;
    end
    if (comps > 0) comps--;
    return 1'b1;
  endfunction

  // Works out the verdict for the edge set held in edge_list, then clears it.
  function automatic verdict_t prune_edges();
    verdict_t vd;
    int n, kept;
    bit shared, ja, jb;
    dufp_pkg::edge_t e;
    n = (nodes_cfg < 1) ? 1 :
        ((nodes_cfg > dufp_pkg::MAX_NODES) ? dufp_pkg::MAX_NODES : int'(nodes_cfg));
    for (int i = 0; i <= dufp_pkg::MAX_NODES; i++) begin
      par_a[i] = i; par_b[i] = i; rank_a[i] = 0; rank_b[i] = 0;
    end
    comps_a = n;
    comps_b = n;
    kept = 0;
    for (int pass = 0; pass < 2; pass++) begin
      foreach (edge_list[i]) begin
        e = edge_list[i];
        shared = (e.etype == dufp_pkg::TYPE_SHARED);
        if (shared != (pass == 0)) continue;
        if (e.u < 1 || e.u > n || e.v < 1 || e.v > n) continue;
        if (shared) begin
          ja = link_nodes(par_a, rank_a, comps_a, e.u, e.v);
          jb = link_nodes(par_b, rank_b, comps_b, e.u, e.v);
          if (ja || jb) kept++;
        end else if (e.etype == dufp_pkg::TYPE_SECOND) begin
          if (link_nodes(par_b, rank_b, comps_b, e.u, e.v)) kept++;
        end else begin
          if (link_nodes(par_a, rank_a, comps_a, e.u, e.v)) kept++;
        end
      end
    end
    vd.traversable = (comps_a == 1) && (comps_b == 1);
    vd.removable = vd.traversable ? 11'(edge_list.size() - kept) : 11'd0;
    vd.overflow = dropped;
    edge_list.delete();
    dropped = 1'b0;
    return vd;
  endfunction

  // Sends one edge word, idling before it at the current sender rate.
  // Valid stays high on return so that the next word can follow at once.
  task automatic send_edge(input logic [1:0] t, input logic [8:0] u, input logic [8:0] v,
                           input logic lst);
    dufp_pkg::edge_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.edge_type <= t;
    in_ch.node_u <= u;
    in_ch.node_v <= v;
    in_ch.last <= lst;
    do @(posedge clk); while (!in_ch.ready);
    e.etype = t; e.u = u; e.v = v;
    if (edge_list.size() < dufp_pkg::MAX_EDGES) edge_list.push_back(e);
    else dropped = 1'b1;
    if (lst) verdict_queue.push_back(prune_edges());
    @(negedge clk);
  endtask

  // Waits until every expected word has arrived, then lets the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (verdict_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_node_count(input logic [8:0] n);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= n;
    do @(posedge clk); while (!cfg_ch.ready);
    nodes_cfg = n;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver ready: random idling, or held low during the pressure test.
  always @(negedge clk) begin
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker: compares each accepted word with the oldest expectation.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_queue.size() == 0) begin
        $display("%0t: unexpected word rem=%0d trav=%0b ovf=%0b", $time,
                 out_ch.removable, out_ch.traversable, out_ch.overflow);
        fail_count++;
      end else begin
        want = verdict_queue.pop_front();
        if (want.removable !== out_ch.removable) begin
          $display("%0t: removable expected %0d actual %0d", $time, want.removable,
                   out_ch.removable);
          fail_count++;
        end
        if (want.traversable !== out_ch.traversable) begin
          $display("%0t: traversable expected %0b actual %0b", $time, want.traversable,
                   out_ch.traversable);
          fail_count++;
        end
        if (want.overflow !== out_ch.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                   out_ch.overflow);
          fail_count++;
        end
      end
    end
  end

  // Random edge set of a given size; mostly in range, with some noise.
  task automatic send_random_set(input int count, input int n);
    logic [1:0] t;
    logic [8:0] u, v;
    for (int i = 0; i < count; i++) begin
      t = ($urandom_range(19) == 0) ? 2'd0 : 2'($urandom_range(3, 1));
      if ($urandom_range(15) == 0) begin
        u = 9'($urandom); v = 9'($urandom);
      end else begin
        u = 9'($urandom_range(n, 1)); v = 9'($urandom_range(n, 1));
      end
      send_edge(t, u, v, i == count - 1);
    end
  endtask

  task automatic test_directed();
    write_node_count(9'd4);
    // A shared chain with redundant and invalid edges: only the chain is kept, the rest is removable.
    send_edge(dufp_pkg::TYPE_SHARED, 9'd1, 9'd2, 1'b0);
    send_edge(dufp_pkg::TYPE_SHARED, 9'd2, 9'd3, 1'b0);
    send_edge(dufp_pkg::TYPE_SHARED, 9'd3, 9'd4, 1'b0);
    send_edge(dufp_pkg::TYPE_FIRST, 9'd1, 9'd4, 1'b0);
    send_edge(dufp_pkg::TYPE_SECOND, 9'd2, 9'd4, 1'b0);
    send_edge(dufp_pkg::TYPE_SHARED, 9'd1, 9'd1, 1'b0);  // self loop
    send_edge(dufp_pkg::TYPE_FIRST, 9'd0, 9'd3, 1'b0);   // endpoint zero
    send_edge(dufp_pkg::TYPE_SECOND, 9'd511, 9'd2, 1'b0); // endpoint beyond the node count
    send_edge(2'd0, 9'd3, 9'd1, 1'b1);         // type zero counts as first user
    // Only first-user edges: not traversable.
    send_edge(dufp_pkg::TYPE_FIRST, 9'd1, 9'd2, 1'b0);
    send_edge(dufp_pkg::TYPE_FIRST, 9'd2, 9'd3, 1'b0);
    send_edge(dufp_pkg::TYPE_FIRST, 9'd3, 9'd4, 1'b1);
    // Single-edge set that ends right away.
    send_edge(dufp_pkg::TYPE_SECOND, 9'd256, 9'd256, 1'b1);
    write_node_count(9'd1);
    send_edge(dufp_pkg::TYPE_SHARED, 9'd1, 9'd1, 1'b1);
    write_node_count(9'd0);
    send_edge(dufp_pkg::TYPE_FIRST, 9'd1, 9'd2, 1'b1);
    write_node_count(9'd511);
    send_edge(dufp_pkg::TYPE_SHARED, 9'd256, 9'd1, 1'b0);
    send_edge(dufp_pkg::TYPE_SHARED, 9'd255, 9'd170, 1'b1);
    write_node_count(9'd256);
    send_edge(dufp_pkg::TYPE_SHARED, 9'd85, 9'd256, 1'b1);
  endtask

  task automatic test_random(input int sets);
    int n, sz;
    for (int s = 0; s < sets; s++) begin
      if ($urandom_range(3) == 0) begin
        n = (s % 3 == 0) ? dufp_pkg::MAX_NODES : $urandom_range(12, 2);
        write_node_count(9'(n));
      end
      n = (nodes_cfg < 1) ? 1 :
          ((nodes_cfg > dufp_pkg::MAX_NODES) ? dufp_pkg::MAX_NODES : int'(nodes_cfg));
      sz = $urandom_range(2 * n + 4, 1);
      if (sz > 40) sz = $urandom_range(40, 1);
      send_random_set(sz, n);
    end
  endtask

  // Receiver holds off for a long stretch while more edge sets wait to be sent.
  task automatic test_backpressure();
    write_node_count(9'd3);
    recv_hold = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk);
        recv_hold = 1'b0;
      end
      begin
        for (int k = 0; k < 6; k++) send_random_set(3, 3);
        in_ch.valid <= 1'b0;
      end
    join
  endtask

  // Fill the store past its capacity so that edges are dropped.
  task automatic test_overflow();
    write_node_count(9'd8);
    send_random_set(dufp_pkg::MAX_EDGES + 5, 8);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.edge_type = '0;
    in_ch.node_u = '0;
    in_ch.node_v = '0;
    in_ch.last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 22; recv_idle_pct = 81;
    test_directed();
    test_random(13);
    send_idle_pct = 81; recv_idle_pct = 22;
    test_random(12);
    test_backpressure();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(14);
    test_overflow();
    drain();
    if (fail_count == 0) begin
      $display("[dual_union_find_edge_pruner] OK");
    end else begin
      $display("[dual_union_find_edge_pruner] ERROR");
    end
    $finish;
  end
endmodule
